>>> rtl/u8u16_pkg.sv
// shared types and constants for the utf-8 to utf-16 transcoder
// no dependencies; used by every module under rtl

package u8u16_pkg;

   // input beat: one byte of utf-8 text
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_text;
   } req_type;

   // result beat: one utf-16 code unit or an error mark
   typedef struct packed {
      logic [15:0] code_unit;
      logic        is_error;
      logic        is_last;
   } rsp_type;

   // decoded event passed from front to back; one or two result beats
   typedef struct packed {
      logic        two_results;
      logic        is_error;
      logic        is_last;
      logic [15:0] unit0;
      logic [15:0] unit1;
   } event_type;

   localparam logic [7:0]  LEAD2_MASK   = 8'hE0;
   localparam logic [7:0]  LEAD2_CODE   = 8'hC0;
   localparam logic [7:0]  LEAD3_MASK   = 8'hF0;
   localparam logic [7:0]  LEAD3_CODE   = 8'hE0;
   localparam logic [7:0]  LEAD4_MASK   = 8'hF8;
   localparam logic [7:0]  LEAD4_CODE   = 8'hF0;
   localparam logic [7:0]  CONT_MASK    = 8'hC0;
   localparam logic [7:0]  CONT_CODE    = 8'h80;
   localparam logic [20:0] CP_MAX       = 21'h10FFFF;
   localparam logic [20:0] CP_BMP_MAX   = 21'h00FFFF;
   localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
   localparam logic [15:0] HI_SURR_BASE = 16'hD800;
   localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

endpackage

>>> rtl/u8u16_front.sv
// front end: byte decoder state machine, turns accepted bytes into events
// depends on u8u16_pkg

module u8u16_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  u8u16_pkg::req_type    req,
   output logic                  push,
   output u8u16_pkg::event_type  evt
);

   logic [1:0]  pending_ff;
   logic [1:0]  pending_in;
   logic [20:0] partial_ff;
   logic [20:0] partial_in;
   logic        discarding_ff;
   logic        discarding_in;

   always_comb begin
      logic [7:0]  b;
      logic        eot;
      logic        bad;
      logic        done;
      logic [20:0] cp;
      logic [20:0] shifted;
      logic [20:0] v;
      b       = req.data_byte;
      eot     = req.end_of_text;
      bad     = 1'b0;
      done    = 1'b0;
      cp      = '0;
      shifted = {partial_ff[14:0], b[5:0]};
      v       = '0;

      pending_in    = pending_ff;
      partial_in    = partial_ff;
      discarding_in = discarding_ff;
      push          = 1'b0;
      evt           = '0;

      if (discarding_ff) begin
         if (eot) begin
            push          = accept;
            evt.is_error  = 1'b1;
            evt.is_last   = 1'b1;
            discarding_in = 1'b0;
            pending_in    = '0;
            partial_in    = '0;
         end
      end else begin
         if (pending_ff == 2'd0) begin
            if (!b[7]) begin
               cp   = {13'd0, b};
               done = 1'b1;
            end else if ((b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_CODE) begin
               pending_in = 2'd1;
               partial_in = {16'd0, b[4:0]};
            end else if ((b & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_CODE) begin
               pending_in = 2'd2;
               partial_in = {17'd0, b[3:0]};
            end else if ((b & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_CODE) begin
               pending_in = 2'd3;
               partial_in = {18'd0, b[2:0]};
            end else begin
               bad = 1'b1;
            end
         end else begin
            if ((b & u8u16_pkg::CONT_MASK) != u8u16_pkg::CONT_CODE) begin
               bad = 1'b1;
            end else begin
               partial_in = shifted;
               pending_in = pending_ff - 2'd1;
               if (pending_ff == 2'd1) begin
                  cp         = shifted;
                  partial_in = '0;
                  done       = 1'b1;
               end
            end
         end

         if (done && (cp > u8u16_pkg::CP_MAX)) bad = 1'b1;
         if (!done && eot) bad = 1'b1;

         v = cp - u8u16_pkg::CP_SUPP_BASE;

         if (bad) begin
            push            = accept;
            evt.is_error    = 1'b1;
            evt.is_last     = eot;
            evt.two_results = eot;
            pending_in      = '0;
            partial_in      = '0;
            discarding_in   = !eot;
         end else if (done) begin
            push        = accept;
            evt.is_last = eot;
            if (cp <= u8u16_pkg::CP_BMP_MAX) begin
               evt.unit0 = cp[15:0];
            end else begin
               evt.two_results = 1'b1;
               evt.unit0       = u8u16_pkg::HI_SURR_BASE + {6'd0, v[19:10]};
               evt.unit1       = u8u16_pkg::LO_SURR_BASE + {6'd0, v[9:0]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         partial_ff    <= '0;
         discarding_ff <= 1'b0;
      end else if (accept) begin
         pending_ff    <= pending_in;
         partial_ff    <= partial_in;
         discarding_ff <= discarding_in;
      end
   end

endmodule

>>> rtl/u8u16_queue.sv
// short event queue between front and back ends
// depends on u8u16_pkg

module u8u16_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  u8u16_pkg::event_type  push_evt,
   input  logic                  pop,
   output u8u16_pkg::event_type  head_evt,
   output logic                  not_empty,
   output logic                  full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   u8u16_pkg::event_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == FULL_CNT);
   assign head_evt  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_evt;
   end

endmodule

>>> rtl/u8u16_back.sv
// back end: expands events into result beats through an output register
// depends on u8u16_pkg

module u8u16_back (
   input  logic                  clock,
   input  logic                  reset,
   input  u8u16_pkg::event_type  head_evt,
   input  logic                  evt_valid,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output u8u16_pkg::rsp_type    rsp
);

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   u8u16_pkg::rsp_type    rsp_ff;
   u8u16_pkg::rsp_type    rsp_in;
   logic                  second_ff;
   logic                  second_in;
   logic                  load;

   assign load      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      second_in    = second_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = evt_valid;
         if (evt_valid) begin
            rsp_in.is_error = head_evt.is_error;
            if (second_ff) begin
               rsp_in.code_unit = head_evt.unit1;
               rsp_in.is_last   = head_evt.is_last;
               second_in        = 1'b0;
               pop              = 1'b1;
            end else if (head_evt.two_results) begin
               rsp_in.code_unit = head_evt.unit0;
               rsp_in.is_last   = 1'b0;
               second_in        = 1'b1;
            end else begin
               rsp_in.code_unit = head_evt.unit0;
               rsp_in.is_last   = head_evt.is_last;
               pop              = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

>>> rtl/utf8_to_utf16_transcoder_unit.sv
// top level of the utf-8 to utf-16 transcoder
// depends on u8u16_pkg, u8u16_front, u8u16_queue, u8u16_back
//
// usage
//   req channel: one utf-8 byte per beat, end_of_text set on the final byte
//   rsp channel: one utf-16 code unit per beat; is_last marks the final beat
//     of a text; a malformed text yields an error beat, then nothing until the
//     final byte, which yields an error beat with is_last set
// timing
//   a byte's first result beat is registered in the event queue, then in the
//   output register, before rsp offers it
//   throughput: one byte and one result beat per cycle unless stalled; a code
//   point above 0xffff gives a surrogate pair that holds the output for two beats
//   the event queue (QUEUE_DEPTH entries) absorbs those extra beats and rsp
//   stalls; req_stall rises only while the queue is full
// reset
//   synchronous, active high; clears the decoder state, the queue and the
//   output register, so the next byte starts a new text
// stalls
//   while rsp_stall is high the output beat holds steady; the front keeps
//   taking bytes until the queue fills

module utf8_to_utf16_transcoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  u8u16_pkg::req_type  req,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output u8u16_pkg::rsp_type  rsp
);

   logic                  req_accept;
   logic                  push;
   logic                  pop;
   logic                  full;
   logic                  not_empty;
   u8u16_pkg::event_type  push_evt;
   u8u16_pkg::event_type  head_evt;

   // front may take a byte whenever the queue has a free slot
   assign req_stall  = full;
   assign req_accept = req_valid && !full;

   // byte decoder
   u8u16_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .req    (req),
      .push   (push),
      .evt    (push_evt)
   );

   // decoupling queue
   u8u16_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_evt  (push_evt),
      .pop       (pop),
      .head_evt  (head_evt),
      .not_empty (not_empty),
      .full      (full)
   );

   // result expansion and output register
   u8u16_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_evt  (head_evt),
      .evt_valid (not_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule

>>> rtl/u8u16_checker.sv
// port-level checks for the transcoder top level
// depends on u8u16_pkg; bound to utf8_to_utf16_transcoder_unit

module u8u16_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input u8u16_pkg::rsp_type  rsp
);

   // stalled result beat stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped under stall");

   // stalled result beat holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp))
      else $error("rsp payload changed under stall");

   // error beats carry a zero code unit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.is_error |-> rsp.code_unit == 16'd0)
      else $error("error beat with nonzero code unit");

   // reset empties the output register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind utf8_to_utf16_transcoder_unit u8u16_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

>>> sim/transcode_checker.sv
`timescale 1ns / 1ps
// checker for the utf-8 to utf-16 transcoder: watches both channels, decodes each
// accepted byte itself and compares every accepted result beat; depends on u8u16_pkg

module transcode_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  u8u16_pkg::req_type  req,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  u8u16_pkg::rsp_type  rsp,
   output int                  mismatch_count,
   output int                  units_outstanding
);

   u8u16_pkg::rsp_type expected_units[$];
   logic [1:0]  cont_left;
   logic [20:0] cp_accum;
   logic        skipping;

   task automatic clear_decoder();
      cont_left = 2'd0;
      cp_accum  = 21'd0;
      skipping  = 1'b0;
   endtask

   task automatic push_unit(input logic [15:0] unit, input logic err, input logic last);
      u8u16_pkg::rsp_type beat;
      beat.code_unit = unit;
      beat.is_error  = err;
      beat.is_last   = last;
      expected_units.insert(expected_units.size(), beat);
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // one byte in, zero to two expected beats out
   task automatic decode_byte(input u8u16_pkg::req_type beat);
      logic [7:0]  b;
      logic        eot;
      logic        bad;
      logic        done;
      logic [20:0] cp;
      logic [20:0] offset;
      b    = beat.data_byte;
      eot  = beat.end_of_text;
      bad  = 1'b0;
      done = 1'b0;
      cp   = 21'd0;
      if (skipping) begin
         if (eot) begin
            push_unit(16'd0, 1'b1, 1'b1);
            clear_decoder();
         end
         return;
      end
      if (cont_left == 2'd0) begin
         if (b[7] == 1'b0) begin
            cp   = {13'd0, b};
            done = 1'b1;
         end else if ((b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_CODE) begin
            cont_left = 2'd1;
            cp_accum  = {16'd0, b[4:0]};
         end else if ((b & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_CODE) begin
            cont_left = 2'd2;
            cp_accum  = {17'd0, b[3:0]};
         end else if ((b & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_CODE) begin
            cont_left = 2'd3;
            cp_accum  = {18'd0, b[2:0]};
         end else begin
            bad = 1'b1;
         end
      end else if ((b & u8u16_pkg::CONT_MASK) != u8u16_pkg::CONT_CODE) begin
         bad = 1'b1;
      end else begin
         cp_accum  = {cp_accum[14:0], b[5:0]};
         cont_left = cont_left - 2'd1;
         if (cont_left == 2'd0) begin
            cp       = cp_accum;
            cp_accum = 21'd0;
            done     = 1'b1;
         end
      end
      if (!bad && done && cp > u8u16_pkg::CP_MAX)
         bad = 1'b1;
      if (!bad && !done && eot)
         bad = 1'b1;
      if (bad) begin
         push_unit(16'd0, 1'b1, 1'b0);
         if (eot) begin
            push_unit(16'd0, 1'b1, 1'b1);
            clear_decoder();
         end else begin
            cont_left = 2'd0;
            cp_accum  = 21'd0;
            skipping  = 1'b1;
         end
         return;
      end
      if (!done)
         return;
      if (eot)
         clear_decoder();
      if (cp <= u8u16_pkg::CP_BMP_MAX) begin
         push_unit(cp[15:0], 1'b0, eot);
      end else begin
         offset = cp - u8u16_pkg::CP_SUPP_BASE;
         push_unit(u8u16_pkg::HI_SURR_BASE + {6'd0, offset[19:10]}, 1'b0, 1'b0);
         push_unit(u8u16_pkg::LO_SURR_BASE + {6'd0, offset[9:0]}, 1'b0, eot);
      end
   endtask

   task automatic check_unit(input u8u16_pkg::rsp_type got);
      u8u16_pkg::rsp_type want;
      if (expected_units.size() == 0) begin
         report_mismatch($sformatf("unexpected beat unit=%h err=%b last=%b",
                                   got.code_unit, got.is_error, got.is_last));
         return;
      end
      want = expected_units.pop_front();
      if (got.code_unit !== want.code_unit || got.is_error !== want.is_error ||
          got.is_last !== want.is_last)
         report_mismatch($sformatf("unit=%h err=%b last=%b, want unit=%h err=%b last=%b",
                                   got.code_unit, got.is_error, got.is_last,
                                   want.code_unit, want.is_error, want.is_last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_units.delete();
         clear_decoder();
      end else begin
         if (req_valid && !req_stall)
            decode_byte(req);
         if (rsp_valid && !rsp_stall)
            check_unit(rsp);
      end
      units_outstanding = expected_units.size();
   end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// top of the transcoder testbench: clock, reset, byte stimulus and rsp stalls
// depends on u8u16_pkg, utf8_to_utf16_transcoder_unit and transcode_checker

module testbench;

   localparam int BYTE_TARGET = 2000;
   localparam int QUIET_FROM  = 1700;   // no idling on either side past this point
   localparam int CYCLE_LIMIT = 500000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   u8u16_pkg::req_type req;
   logic               rsp_valid;
   logic               rsp_stall;
   u8u16_pkg::rsp_type rsp;

   int mismatch_count;
   int units_outstanding;
   int cycle_count;
   int bytes_sent;
   int idle_odds;          // 1 in idle_odds chance of a burst; 0 disables idling
   int stall_left;
   logic req_taken;        // byte accepted at the last rising edge
   logic [7:0] text_bytes[$];

   utf8_to_utf16_transcoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   transcode_checker transcode_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req               (req),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp               (rsp),
      .mismatch_count    (mismatch_count),
      .units_outstanding (units_outstanding)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // handshake seen at the rising edge, read back at the falling edge
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      cycle_count <= cycle_count + 1;
   end

   // timeout guard
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // receiver back-pressure: random bursts of stalled cycles
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else if (!reset && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         rsp_stall = 1'b1;
         stall_left = $urandom_range(0, 12);
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // one beat on req, possibly after a gap; returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] value, input logic eot);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid = 1'b1;
      req.data_byte = value;
      req.end_of_text = eot;
      do @(negedge clock); while (!req_taken);
      bytes_sent++;
   endtask

   // sends the built text with end_of_text on its final byte, then clears it
   task automatic send_text();
      for (int i = 0; i < text_bytes.size(); i++)
         send_byte(text_bytes[i], i == text_bytes.size() - 1);
      text_bytes.delete();
   endtask

   // adds one byte at the end of the text being built
   task automatic add_byte(input logic [7:0] value);
      text_bytes.insert(text_bytes.size(), value);
   endtask

   // utf-8 encoding of the low bits of cp in len bytes, overlong forms allowed
   task automatic append_char(input logic [20:0] cp, input int len);
      case (len)
         1: add_byte({1'b0, cp[6:0]});
         2: begin
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
         end
         3: begin
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
         end
         default: begin
            add_byte({5'b11110, cp[20:18]});
            add_byte({2'b10, cp[17:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
         end
      endcase
   endtask

   // text of random characters of every length; a 4-byte one may lie past 0x10ffff
   task automatic build_clean_text();
      int chars;
      int len;
      logic [20:0] cp;
      chars = $urandom_range(1, 10);
      repeat (chars) begin
         len = $urandom_range(1, 4);
         cp = 21'($urandom);
         // mostly in-range supplementary points, sometimes past 0x10ffff
         if (len == 4 && $urandom_range(0, 7) != 0)
            cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
         append_char(cp, len);
      end
   endtask

   task automatic run_random_text();
      int pick;
      int cut;
      pick = $urandom_range(0, 99);
      build_clean_text();
      if (pick >= 70 && pick < 80) begin
         // one byte replaced by anything
         text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom);
      end else if (pick >= 80 && pick < 88) begin
         // cut short, often mid-sequence
         cut = $urandom_range(1, 3);
         while (cut != 0 && text_bytes.size() > 1) begin
            void'(text_bytes.pop_back());
            cut--;
         end
      end else if (pick >= 88) begin
         // pure noise
         text_bytes.delete();
         repeat ($urandom_range(1, 8))
            add_byte(8'($urandom));
      end
      send_text();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req = '0;
      rsp_stall = 1'b0;
      stall_left = 0;
      idle_odds = 0;
      bytes_sent = 0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed: ascii extremes, 2/3/4 byte forms ending on a surrogate pair
      idle_odds = 4;
      text_bytes = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                     8'hF0, 8'h9F, 8'h98, 8'h80};
      send_text();
      // highest legal code point
      text_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
      send_text();
      // largest 21-bit value, out of range on the final byte
      text_bytes = '{8'hF7, 8'hBF, 8'hBF, 8'hBF};
      send_text();
      // stray continuation byte as the only byte
      text_bytes = '{8'h80};
      send_text();
      // invalid lead, then a discarded byte closing the text
      text_bytes = '{8'hFF, 8'h41};
      send_text();
      // lead byte followed by ascii instead of a continuation
      text_bytes = '{8'hC3, 8'h41};
      send_text();
      // text ending mid-sequence
      text_bytes = '{8'hE2, 8'h82};
      send_text();

      // random texts, idling mode changing per text, calm tail at the end
      while (bytes_sent < BYTE_TARGET) begin
         if (bytes_sent >= QUIET_FROM) begin
            idle_odds = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: idle_odds = 0;
               1: idle_odds = 16;
               default: idle_odds = 3;
            endcase
         end
         run_random_text();
      end
      idle_odds = 0;
      req_valid = 1'b0;

      // drain, then wait for stray beats
      while (units_outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
